@@ hdl/ukt_pkg.sv @@
package ukt_pkg;

    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int POS_IN_W  = 8;
    localparam int FPOS_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 3;
    localparam int ACTION_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Per-cell control from the table controller.
    typedef struct packed {
        logic capture;  // register the match line for the item just taken
        logic by_pos;   // match on position (get) rather than on key
        logic live;     // cell lies below the live count
        logic append;   // write the new entry into this cell
        logic shift;    // take the entry of the next cell up
    } t_cell_ctl;

endpackage

@@ hdl/unique_key_table_with_compaction.sv @@
// Channel | Valid        | Stall        | Payload
// input   | i_in_valid   | o_in_stall   | i_action, i_key, i_payload, i_position
// output  | o_out_valid  | i_out_stall  | o_status, o_found_position, o_key_out,
//         |              |              | o_payload_out, o_live_count
//
// Each item passes through S_IDLE and then S_EXEC: the cells register their match
// lines in the cycle of the transfer, and S_EXEC resolves the first match and
// updates the row. A new item is taken only once the previous one has left S_EXEC.
// A result held by i_out_stall holds the update cycle; the input is stalled meanwhile.
// Reset clears the entry count and the handshake state; the cells need no clearing.
module unique_key_table_with_compaction import ukt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ACTION_W-1:0]         i_action,
    input  logic signed [KEY_W-1:0]     i_key,
    input  logic [PAYLOAD_W-1:0]        i_payload,
    input  logic [POS_IN_W-1:0]         i_position,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [STATUS_W-1:0]         o_status,
    output logic [FPOS_W-1:0]           o_found_position,
    output logic signed [KEY_W-1:0]     o_key_out,
    output logic [PAYLOAD_W-1:0]        o_payload_out,
    output logic [COUNT_W-1:0]          o_live_count
);

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > POS_IN_W) ? CW : POS_IN_W;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [ACTION_W-1:0]    r_action;
    logic [KEY_W-1:0]       r_key;
    logic [PAYLOAD_W-1:0]   r_payload;
    logic [POS_IN_W-1:0]    r_position;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [FPOS_W-1:0]      r_fpos;
    logic [KEY_W-1:0]       r_kout;
    logic [PAYLOAD_W-1:0]   r_pout;
    logic [COUNT_W-1:0]     r_cnt_out;

    logic                   w_accept;
    logic                   w_exec;
    logic                   w_out_free;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_any;
    logic                   w_range;
    logic                   w_do_append;
    logic                   w_do_shift;
    logic [TABLE_DEPTH-1:0] w_match;
    logic [TABLE_DEPTH-1:0] w_first;
    logic [TABLE_DEPTH-1:0] w_ge;
    logic [IW-1:0]          w_pos;
    logic [KEY_W-1:0]       w_sel_key;
    logic [PAYLOAD_W-1:0]   w_sel_payload;
    logic [STATUS_W-1:0]    n_status;
    logic [FPOS_W-1:0]      n_fpos;
    logic [KEY_W-1:0]       n_kout;
    logic [PAYLOAD_W-1:0]   n_pout;

    logic [KEY_W-1:0]       w_cell_key[TABLE_DEPTH];
    logic [PAYLOAD_W-1:0]   w_cell_payload[TABLE_DEPTH];
    t_cell_ctl              w_ctl[TABLE_DEPTH];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_exec     = (r_state == S_EXEC) && w_out_free;

    assign w_full  = (r_count == CW'(TABLE_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_any   = |w_match;
    assign w_range = (CMPW'(r_position) >= CMPW'(r_count));

    // Isolate the lowest match; every cell at or above it shifts on removal.
    assign w_first = w_match & (~w_match + TABLE_DEPTH'(1));
    assign w_ge    = ~(w_first - TABLE_DEPTH'(1));

    always_comb begin
        w_pos         = '0;
        w_sel_key     = '0;
        w_sel_payload = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_first[i]) begin
                w_pos         = w_pos | IW'(i);
                w_sel_key     = w_sel_key | w_cell_key[i];
                w_sel_payload = w_sel_payload | w_cell_payload[i];
            end
        end
    end

    always_comb begin
        n_status    = ST_OK;
        n_fpos      = '0;
        n_kout      = '0;
        n_pout      = '0;
        n_count     = r_count;
        w_do_append = 1'b0;
        w_do_shift  = 1'b0;
        unique case (r_action) inside
            ACT_ADD: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (w_any) begin
                    n_status = ST_DUP;
                end else begin
                    w_do_append = 1'b1;
                    n_count     = r_count + CW'(1);
                end
            end
            ACT_FIND, ACT_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_any) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_fpos = FPOS_W'(w_pos);
                    if (r_action == ACT_REMOVE) begin
                        w_do_shift = 1'b1;
                        n_count    = r_count - CW'(1);
                    end
                end
            end
            ACT_GET: begin
                n_kout = '1;
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_kout = w_sel_key;
                    n_pout = w_sel_payload;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            assign w_ctl[g].capture = w_accept;
            assign w_ctl[g].by_pos  = (i_action == ACT_GET);
            assign w_ctl[g].live    = (r_count > CW'(g));
            assign w_ctl[g].append  = w_exec && w_do_append && (r_count == CW'(g));
            assign w_ctl[g].shift   = w_exec && w_do_shift && w_ge[g];

            if (g == TABLE_DEPTH - 1) begin : g_top
                ukt_cell #(.INDEX(g)) u_cell (
                    .i_clk          (i_clk),
                    .i_ctl          (w_ctl[g]),
                    .i_cmp_key      (i_key),
                    .i_cmp_pos      (i_position),
                    .i_new_key      (r_key),
                    .i_new_payload  (r_payload),
                    .i_next_key     (w_cell_key[g]),
                    .i_next_payload (w_cell_payload[g]),
                    .o_key          (w_cell_key[g]),
                    .o_payload      (w_cell_payload[g]),
                    .o_match        (w_match[g])
                );
            end else begin : g_mid
                ukt_cell #(.INDEX(g)) u_cell (
                    .i_clk          (i_clk),
                    .i_ctl          (w_ctl[g]),
                    .i_cmp_key      (i_key),
                    .i_cmp_pos      (i_position),
                    .i_new_key      (r_key),
                    .i_new_payload  (r_payload),
                    .i_next_key     (w_cell_key[g+1]),
                    .i_next_payload (w_cell_payload[g+1]),
                    .o_key          (w_cell_key[g]),
                    .o_payload      (w_cell_payload[g]),
                    .o_match        (w_match[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action   <= i_action;
            r_key      <= i_key;
            r_payload  <= i_payload;
            r_position <= i_position;
        end
        if (w_exec) begin
            r_status  <= n_status;
            r_fpos    <= n_fpos;
            r_kout    <= n_kout;
            r_pout    <= n_pout;
            r_cnt_out <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_key_out        = r_kout;
    assign o_payload_out    = r_pout;
    assign o_live_count     = r_cnt_out;

    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without an update cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(w_exec) |-> $stable(r_count))
        else $error("entry count changed outside an update cycle");

    a_get_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && (r_action == ACT_GET) |-> $onehot0(w_match))
        else $error("more than one cell selected by position");

    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && !w_out_free |=> (r_state == S_EXEC))
        else $error("update cycle left while the result register was held");

endmodule

@@ hdl/ukt_cell.sv @@
module ukt_cell import ukt_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [KEY_W-1:0]     i_cmp_key,
    input  logic [POS_IN_W-1:0]  i_cmp_pos,
    input  logic [KEY_W-1:0]     i_new_key,
    input  logic [PAYLOAD_W-1:0] i_new_payload,
    input  logic [KEY_W-1:0]     i_next_key,
    input  logic [PAYLOAD_W-1:0] i_next_payload,
    output logic [KEY_W-1:0]     o_key,
    output logic [PAYLOAD_W-1:0] o_payload,
    output logic                 o_match
);

    logic [KEY_W-1:0]     r_key;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                 r_match;
    logic                 n_match;

    always_comb begin
        if (i_ctl.by_pos) begin
            n_match = i_ctl.live && ({{(32-POS_IN_W){1'b0}}, i_cmp_pos} == 32'(INDEX));
        end else begin
            n_match = i_ctl.live && (r_key == i_cmp_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= n_match;
        end
        if (i_ctl.append) begin
            r_key     <= i_new_key;
            r_payload <= i_new_payload;
        end else if (i_ctl.shift) begin
            r_key     <= i_next_key;
            r_payload <= i_next_payload;
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_match   = r_match;

endmodule
